[src/sha3_pkg.sv]
// shared types, constants and the keccak-f[1600] round function for the sha3-256 block
package sha3_pkg;

    localparam int unsigned RATE_LANES = 17;
    localparam int unsigned NUM_ROUNDS = 24;
    localparam int unsigned LANE_W     = 64;

    localparam logic [7:0]        PAD_DOMAIN = 8'h06;
    localparam logic [LANE_W-1:0] PAD_END    = 64'h8000_0000_0000_0000;

    // rotation offsets indexed [x][y]
    localparam int unsigned RHO_OFFSET [0:4][0:4] = '{
        '{ 0, 36,  3, 41, 18},
        '{ 1, 44, 10, 45,  2},
        '{62,  6, 43, 15, 61},
        '{28, 55, 25, 21, 56},
        '{27, 20, 39,  8, 14}
    };

    typedef logic [24:0][LANE_W-1:0] t_lanes;
    typedef logic [3:0][LANE_W-1:0]  t_digest;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_FINISH
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       absorb;     // xor the input word into the current lane
        logic       pad_short;  // input is a short last word: mask, pad, close block
        logic       pad_full;   // pad after a full last word
        logic       round_en;   // run one keccak round
        logic [4:0] round_idx;
        logic       load_out;   // hand the digest over and clear the sponge
    } t_dp_cmd;

    typedef struct packed {
        logic block_full;       // next absorbed word completes the rate part
    } t_dp_status;

    function automatic logic [LANE_W-1:0] round_const(input logic [4:0] idx);
        logic [LANE_W-1:0] rc;
        case (idx)
            5'd0:    rc = 64'h0000_0000_0000_0001;
            5'd1:    rc = 64'h0000_0000_0000_8082;
            5'd2:    rc = 64'h8000_0000_0000_808A;
            5'd3:    rc = 64'h8000_0000_8000_8000;
            5'd4:    rc = 64'h0000_0000_0000_808B;
            5'd5:    rc = 64'h0000_0000_8000_0001;
            5'd6:    rc = 64'h8000_0000_8000_8081;
            5'd7:    rc = 64'h8000_0000_0000_8009;
            5'd8:    rc = 64'h0000_0000_0000_008A;
            5'd9:    rc = 64'h0000_0000_0000_0088;
            5'd10:   rc = 64'h0000_0000_8000_8009;
            5'd11:   rc = 64'h0000_0000_8000_000A;
            5'd12:   rc = 64'h0000_0000_8000_808B;
            5'd13:   rc = 64'h8000_0000_0000_008B;
            5'd14:   rc = 64'h8000_0000_0000_8089;
            5'd15:   rc = 64'h8000_0000_0000_8003;
            5'd16:   rc = 64'h8000_0000_0000_8002;
            5'd17:   rc = 64'h8000_0000_0000_0080;
            5'd18:   rc = 64'h0000_0000_0000_800A;
            5'd19:   rc = 64'h8000_0000_8000_000A;
            5'd20:   rc = 64'h8000_0000_8000_8081;
            5'd21:   rc = 64'h8000_0000_0000_8080;
            5'd22:   rc = 64'h0000_0000_8000_0001;
            5'd23:   rc = 64'h8000_0000_8000_8008;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    // one round: theta, rho, pi, chi, iota
    function automatic t_lanes keccak_round(input t_lanes a, input logic [LANE_W-1:0] rc);
        logic [4:0][LANE_W-1:0] c;
        logic [4:0][LANE_W-1:0] d;
        t_lanes                 t;
        t_lanes                 b;
        t_lanes                 r;
        logic [2*LANE_W-1:0]    dbl;
        for (int x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[(x+4)%5] ^ {c[(x+1)%5][LANE_W-2:0], c[(x+1)%5][LANE_W-1]};
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                t[x+5*y] = a[x+5*y] ^ d[x];
            end
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                dbl = {t[x+5*y], t[x+5*y]} << RHO_OFFSET[x][y];
                b[y+5*((2*x+3*y)%5)] = dbl[2*LANE_W-1:LANE_W];
            end
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                r[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
            end
        end
        r[0] = r[0] ^ rc;
        return r;
    endfunction

endpackage

[src/sha3_dp.sv]
// sponge datapath: lane state, absorb and pad logic, one keccak round per cycle
module sha3_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha3_pkg::t_dp_cmd    i_cmd,
    input  logic [63:0]          i_word,
    input  logic [3:0]           i_count,
    output sha3_pkg::t_dp_status o_status,
    output sha3_pkg::t_digest    o_digest
);

    sha3_pkg::t_lanes r_lanes;
    sha3_pkg::t_lanes n_lanes;
    logic [4:0]       r_pos;
    logic [4:0]       n_pos;

    logic [5:0]       shift_amt;
    logic [63:0]      keep_mask;
    logic [63:0]      pad_word;
    logic [63:0]      absorb_word;
    logic             block_full;

    // short words only: count is below eight here
    assign shift_amt   = {i_count[2:0], 3'b000};
    assign keep_mask   = ~({64{1'b1}} << shift_amt);
    assign pad_word    = {56'd0, sha3_pkg::PAD_DOMAIN} << shift_amt;
    assign absorb_word = i_cmd.pad_short ? ((i_word & keep_mask) ^ pad_word) : i_word;
    assign block_full  = (r_pos == 5'(sha3_pkg::RATE_LANES - 1));

    always_comb begin
        n_lanes = r_lanes;
        n_pos   = r_pos;
        if (i_cmd.load_out) begin
            n_lanes = '0;
            n_pos   = '0;
        end else if (i_cmd.round_en) begin
            n_lanes = sha3_pkg::keccak_round(r_lanes, sha3_pkg::round_const(i_cmd.round_idx));
        end else if (i_cmd.absorb) begin
            n_lanes[r_pos] = r_lanes[r_pos] ^ absorb_word;
            if (i_cmd.pad_short) begin
                n_lanes[sha3_pkg::RATE_LANES-1] =
                    n_lanes[sha3_pkg::RATE_LANES-1] ^ sha3_pkg::PAD_END;
            end
            n_pos = block_full ? 5'd0 : r_pos + 5'd1;
        end else if (i_cmd.pad_full) begin
            n_lanes[r_pos] = r_lanes[r_pos] ^ {56'd0, sha3_pkg::PAD_DOMAIN};
            n_lanes[sha3_pkg::RATE_LANES-1] =
                n_lanes[sha3_pkg::RATE_LANES-1] ^ sha3_pkg::PAD_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= '0;
            r_pos   <= '0;
        end else begin
            r_lanes <= n_lanes;
            r_pos   <= n_pos;
        end
    end

    assign o_status.block_full = block_full;
    assign o_digest            = r_lanes[3:0];

endmodule

[src/sha3_out.sv]
// digest buffer that drains four result words onto the output stream
module sha3_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sha3_pkg::t_digest i_digest,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic [63:0]       o_word,
    output logic [1:0]        o_idx,
    output logic              o_last,
    output logic              o_busy
);

    sha3_pkg::t_digest r_words;
    logic [1:0]        r_idx;
    logic              r_valid;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words <= i_digest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_tready) begin
            if (r_idx == 2'd3) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    assign o_tvalid = r_valid;
    assign o_word   = r_words[r_idx];
    assign o_idx    = r_idx;
    assign o_last   = (r_idx == 2'd3);
    assign o_busy   = r_valid;

endmodule

[src/sha3_ctrl.sv]
// controller: absorb sequencing, round counting, padding and digest handover
module sha3_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    input  logic [3:0]           i_in_count,
    input  sha3_pkg::t_dp_status i_status,
    input  logic                 i_out_busy,
    output logic                 o_in_ready,
    output sha3_pkg::t_dp_cmd    o_cmd
);

    sha3_pkg::t_state r_state;
    sha3_pkg::t_state n_state;
    logic [4:0]       r_round;
    logic [4:0]       n_round;
    logic             r_final;
    logic             n_final;
    logic             r_pad_pend;
    logic             n_pad_pend;

    logic             accept;
    logic             count_full;
    logic             last_round;

    assign accept     = (r_state == sha3_pkg::ST_IDLE) && i_in_valid;
    // counts of eight and above take the whole word
    assign count_full = i_in_count[3];
    assign last_round = (r_round == 5'(sha3_pkg::NUM_ROUNDS - 1));

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_final    = r_final;
        n_pad_pend = r_pad_pend;
        case (r_state)
            sha3_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_last && !count_full) begin
                        n_state = sha3_pkg::ST_ROUND;
                        n_final = 1'b1;
                    end else if (i_in_last) begin
                        if (i_status.block_full) begin
                            n_state    = sha3_pkg::ST_ROUND;
                            n_pad_pend = 1'b1;
                        end else begin
                            n_state = sha3_pkg::ST_PAD;
                        end
                    end else if (i_status.block_full) begin
                        n_state = sha3_pkg::ST_ROUND;
                    end
                end
            end
            sha3_pkg::ST_ROUND: begin
                n_round = r_round + 5'd1;
                if (last_round) begin
                    n_round = '0;
                    if (r_final) begin
                        n_state = sha3_pkg::ST_FINISH;
                    end else if (r_pad_pend) begin
                        n_state    = sha3_pkg::ST_PAD;
                        n_pad_pend = 1'b0;
                    end else begin
                        n_state = sha3_pkg::ST_IDLE;
                    end
                end
            end
            sha3_pkg::ST_PAD: begin
                n_state = sha3_pkg::ST_ROUND;
                n_final = 1'b1;
            end
            sha3_pkg::ST_FINISH: begin
                if (!i_out_busy) begin
                    n_state = sha3_pkg::ST_IDLE;
                    n_final = 1'b0;
                end
            end
            default: begin
                n_state = sha3_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.round_idx = r_round;
        case (r_state)
            sha3_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.absorb    = accept;
                o_cmd.pad_short = accept && i_in_last && !count_full;
            end
            sha3_pkg::ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            sha3_pkg::ST_PAD: begin
                o_cmd.pad_full = 1'b1;
            end
            sha3_pkg::ST_FINISH: begin
                o_cmd.load_out = !i_out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha3_pkg::ST_IDLE;
            r_round    <= '0;
            r_final    <= 1'b0;
            r_pad_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_final    <= n_final;
            r_pad_pend <= n_pad_pend;
        end
    end

endmodule

[src/sha3_256_hash.sv]
// top level of the streaming sha3-256 hash block
// Streaming SHA3-256. Each input transfer carries one little-endian 64-bit message word
// (first byte in bits 7:0) and a byte count; tlast marks the final transfer of a message,
// and only that one may be short or empty (counts above eight act as eight). A word that
// is not last is just absorbed; the seventeenth word of a block then starts the
// Keccak-f[1600] permutation, which runs on a single round unit at one round per cycle.
// The last transfer is padded with the 0x06 domain byte and the closing 0x80 bit: a short
// word pads in its own absorb cycle and is followed by 24 rounds; a full last word is
// padded in a separate pad state, after another 24 rounds when it completes a block.
// The handover state then passes the digest to the output buffer once it is free and
// clears the sponge, after which the next message may start at once. The 256-bit digest
// leaves as four transfers, lane 0 first, with tlast on the fourth; it waits in that
// buffer, so output stalls only hold up a following message at its own final handover.
// The input is not ready while rounds or padding run.
module sha3_256_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] digest_word, [65:64] word_index, [71:66] zero
    output logic        m_axis_tlast    // last_word
);

    sha3_pkg::t_dp_cmd    dp_cmd;
    sha3_pkg::t_dp_status dp_status;
    sha3_pkg::t_digest    digest;
    logic                 out_busy;
    logic [63:0]          out_word;
    logic [1:0]           out_idx;

    // sequencing of absorb, rounds, padding and handover
    sha3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_in_count (s_axis_tdata[67:64]),
        .i_status   (dp_status),
        .i_out_busy (out_busy),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    // 1600-bit sponge state and the round logic
    sha3_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_word   (s_axis_tdata[63:0]),
        .i_count  (s_axis_tdata[67:64]),
        .o_status (dp_status),
        .o_digest (digest)
    );

    // digest buffer, decouples the output stream from the sponge
    sha3_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (dp_cmd.load_out),
        .i_digest (digest),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_word   (out_word),
        .o_idx    (out_idx),
        .o_last   (m_axis_tlast),
        .o_busy   (out_busy)
    );

    assign m_axis_tdata = {6'd0, out_idx, out_word};

endmodule

[verif/sha3_digest_checker.sv]
// checker for the sha3-256 block: tracks the sponge, predicts digests and compares output transfers
module sha3_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [71:0] i_in_tdata,    // [63:0] data_word, [67:64] byte_count, [71:68] zero
    input  logic        i_in_tlast,    // last_item
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [71:0] i_out_tdata,   // [63:0] digest_word, [65:64] word_index, [71:66] zero
    input  logic        i_out_tlast,   // last_word
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RATE_WORDS   = 17;
    localparam int unsigned ROUND_COUNT  = 24;
    localparam int unsigned DIGEST_WORDS = 4;
    localparam logic [63:0] DOMAIN_PAD   = 64'h06;
    localparam logic [63:0] CLOSE_PAD    = 64'h8000_0000_0000_0000;

    localparam logic [63:0] IOTA_CONST [ROUND_COUNT] = '{
        64'h0000_0000_0000_0001, 64'h0000_0000_0000_8082,
        64'h8000_0000_0000_808A, 64'h8000_0000_8000_8000,
        64'h0000_0000_0000_808B, 64'h0000_0000_8000_0001,
        64'h8000_0000_8000_8081, 64'h8000_0000_0000_8009,
        64'h0000_0000_0000_008A, 64'h0000_0000_0000_0088,
        64'h0000_0000_8000_8009, 64'h0000_0000_8000_000A,
        64'h0000_0000_8000_808B, 64'h8000_0000_0000_008B,
        64'h8000_0000_0000_8089, 64'h8000_0000_0000_8003,
        64'h8000_0000_0000_8002, 64'h8000_0000_0000_0080,
        64'h0000_0000_0000_800A, 64'h8000_0000_8000_000A,
        64'h8000_0000_8000_8081, 64'h8000_0000_0000_8080,
        64'h0000_0000_8000_0001, 64'h8000_0000_8000_8008
    };

    // lane rotation, indexed [x][y]
    localparam int unsigned LANE_ROT [5][5] = '{
        '{ 0, 36,  3, 41, 18},
        '{ 1, 44, 10, 45,  2},
        '{62,  6, 43, 15, 61},
        '{28, 55, 25, 21, 56},
        '{27, 20, 39,  8, 14}
    };

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  lane;
        logic        last;
    } t_digest_beat;

    logic [63:0]  sponge [25];
    int unsigned  absorb_lane;
    t_digest_beat digest_q [$];

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
        int unsigned k;
        k = n % 64;
        if (k == 0) return v;
        return (v << k) | (v >> (64 - k));
    endfunction

    task automatic sponge_clear();
        for (int i = 0; i < 25; i++) sponge[i] = '0;
        absorb_lane = 0;
    endtask

    // keccak-f[1600], all 24 rounds at once
    task automatic keccak_f();
        logic [63:0] c [5];
        logic [63:0] d [5];
        logic [63:0] b [25];
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int x = 0; x < 5; x++) begin
                c[x] = sponge[x] ^ sponge[x+5] ^ sponge[x+10] ^ sponge[x+15] ^ sponge[x+20];
            end
            for (int x = 0; x < 5; x++) begin
                d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
            end
            for (int x = 0; x < 5; x++) begin
                for (int y = 0; y < 5; y++) sponge[x+5*y] ^= d[x];
            end
            for (int x = 0; x < 5; x++) begin
                for (int y = 0; y < 5; y++) begin
                    b[y+5*((2*x+3*y)%5)] = rotl(sponge[x+5*y], LANE_ROT[x][y]);
                end
            end
            for (int x = 0; x < 5; x++) begin
                for (int y = 0; y < 5; y++) begin
                    sponge[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
                end
            end
            sponge[0] ^= IOTA_CONST[r];
        end
    endtask

    task automatic absorb_word(input logic [63:0] w);
        sponge[absorb_lane] ^= w;
        absorb_lane++;
        if (absorb_lane == RATE_WORDS) begin
            keccak_f();
            absorb_lane = 0;
        end
    endtask

    // one input transfer; a last one pads, permutes and queues the four digest words
    task automatic absorb_transfer(input logic [63:0] w, input logic [3:0] count_in,
                                   input logic last);
        int unsigned  nbytes;
        logic [63:0]  keep;
        t_digest_beat beat;
        nbytes = (count_in > 8) ? 8 : count_in;
        if (!last) begin
            absorb_word(w);
            return;
        end
        if (nbytes == 8) begin
            absorb_word(w);
            sponge[absorb_lane] ^= DOMAIN_PAD;
        end else begin
            keep = (nbytes == 0) ? '0 : ({64{1'b1}} >> (64 - 8 * nbytes));
            sponge[absorb_lane] ^= (w & keep) ^ (DOMAIN_PAD << (8 * nbytes));
        end
        sponge[RATE_WORDS-1] ^= CLOSE_PAD;
        keccak_f();
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            beat.word = sponge[i];
            beat.lane = 2'(i);
            beat.last = (i == DIGEST_WORDS - 1);
            digest_q  = {digest_q, beat};
        end
        sponge_clear();
    endtask

    task automatic check_digest_transfer();
        t_digest_beat want;
        if (digest_q.size() == 0) begin
            $display("%0t: digest transfer with none expected, got %h last %b", $time,
                     i_out_tdata, i_out_tlast);
            o_fail_count++;
            return;
        end
        want = digest_q.pop_front();
        if (i_out_tdata[63:0] !== want.word) begin
            $display("%0t: digest word mismatch, expected %h, got %h", $time,
                     want.word, i_out_tdata[63:0]);
            o_fail_count++;
        end
        if (i_out_tdata[65:64] !== want.lane) begin
            $display("%0t: word index mismatch, expected %0d, got %0d", $time,
                     want.lane, i_out_tdata[65:64]);
            o_fail_count++;
        end
        if (i_out_tlast !== want.last) begin
            $display("%0t: last word mismatch, expected %b, got %b", $time,
                     want.last, i_out_tlast);
            o_fail_count++;
        end
        if (i_out_tdata[71:66] !== 6'b0) begin
            $display("%0t: tdata fill mismatch, expected %h, got %h", $time,
                     6'b0, i_out_tdata[71:66]);
            o_fail_count++;
        end
    endtask

    // outputs are checked before the input is absorbed so a stray transfer is never hidden
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sponge_clear();
            digest_q.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) check_digest_transfer();
            if (i_in_tvalid && i_in_tready) begin
                absorb_transfer(i_in_tdata[63:0], i_in_tdata[67:64], i_in_tlast);
            end
        end
        o_pending = digest_q.size();
    end

endmodule

[verif/tb_sha3_256_hash.sv]
// testbench top for the sha3-256 block: message stimulus, output stalls and the verdict
module tb_sha3_256_hash;
    timeunit 1ns;
    timeprecision 1ps;

    // no transfer on either side for this long means the block is hung
    localparam int STALL_LIMIT  = 2000;
    // a full last word can cost two permutations plus padding and handover
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;    // [63:0] data_word, [67:64] byte_count, [71:68] zero
    logic        s_axis_tlast  = 1'b0;  // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [63:0] digest_word, [65:64] word_index, [71:66] zero
    logic        m_axis_tlast;          // last_word

    int fail_count;
    int digests_pending;
    int send_idle_pct = 20;
    int recv_idle_pct = 79;
    int transfers_sent = 0;
    int idle_cycles = 0;

    sha3_256_hash u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha3_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tlast   (s_axis_tlast),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tlast  (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (digests_pending)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // hang detection: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // message words: mostly random, sometimes all zeros or all ones
    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one input transfer; idle gaps carry junk on tdata and tlast
    task automatic send_transfer(input logic [63:0] w, input logic [3:0] count,
                                 input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {4'h0, 4'($urandom), $urandom, $urandom};
            s_axis_tlast  = 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'h0, count, w};
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        transfers_sent++;
    endtask

    // body words carry random byte counts, which the block must ignore
    task automatic send_message(input int body_words, input logic [3:0] last_count);
        for (int i = 0; i < body_words; i++) send_transfer(pick_word(), 4'($urandom), 1'b0);
        send_transfer(pick_word(), last_count, 1'b1);
    endtask

    // random message: lengths cluster around block edges so that full last words
    // close a block and the pad byte lands in the final rate byte often enough
    task automatic send_random_message();
        int          shape;
        int          body_words;
        logic [3:0]  last_count;
        shape = $urandom_range(99);
        if (shape < 40)      body_words = $urandom_range(3, 0);
        else if (shape < 70) body_words = $urandom_range(17, 15);
        else if (shape < 85) body_words = $urandom_range(34, 32);
        else                 body_words = $urandom_range(14, 4);
        shape = $urandom_range(99);
        if (shape < 45)      last_count = 4'($urandom_range(7, 0));
        else if (shape < 75) last_count = 4'd8;
        else                 last_count = 4'($urandom_range(15, 9));
        send_message(body_words, last_count);
    endtask

    initial begin
        // reset held at the start, then released at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message
        send_transfer('0, 4'd0, 1'b1);
        // three-byte message with junk above the valid bytes
        send_transfer(64'hFFFF_FFFF_FF63_6261, 4'd3, 1'b1);
        // one full last word of all ones
        send_transfer('1, 4'd8, 1'b1);
        // byte count above eight on a last word acts as eight
        send_transfer('0, 4'd15, 1'b1);
        // sixteen body words, then seven bytes: domain pad meets the closing bit
        for (int i = 0; i < 16; i++) send_transfer('1, 4'(i), 1'b0);
        send_transfer('1, 4'd7, 1'b1);

        // random messages in three stall regimes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (transfers_sent < 66 + 67 * phase) send_random_message();
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        // drain: every digest delivered, then a quiet spell for strays
        while (digests_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && digests_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
